// ===== rtl/spf_pkg.sv =====
// Shared types and constants of the servo packet framer.
`default_nettype none

package spf_pkg;

    // Operation codes of a command word.
    typedef enum logic [2:0] {
        OP_ENABLE  = 3'd0,
        OP_DISABLE = 3'd1,
        OP_READ    = 3'd2,
        OP_SET     = 3'd3,
        OP_RX_BYTE = 3'd4
    } spf_op_t;

    // Frame types handed from the front end to the serializer.
    typedef enum logic [1:0] {
        FRM_ENABLE  = 2'd0,
        FRM_DISABLE = 2'd1,
        FRM_READ    = 2'd2,
        FRM_SET     = 2'd3
    } spf_frame_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SERVO_ID  = 2'd0,
        CFG_POS_MIN   = 2'd1,
        CFG_POS_MAX   = 2'd2,
        CFG_VEL_LIMIT = 2'd3
    } spf_cfg_idx_t;

    typedef struct packed {
        logic [7:0]  servo_id;
        logic [15:0] pos_min;
        logic [15:0] pos_max;
        logic [15:0] vel_limit;
    } spf_cfg_t;

    // One unit of work for the serializer: a whole frame or one report.
    typedef struct packed {
        logic        is_report;
        spf_frame_t  frame;
        logic [15:0] pos;
        logic [15:0] vel;
    } spf_job_t;

    localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
    localparam logic [7:0]  LEN_SHORT   = 8'h04;
    localparam logic [7:0]  LEN_SET     = 8'h09;
    localparam logic [7:0]  INST_READ   = 8'h02;
    localparam logic [7:0]  INST_WRITE  = 8'h03;
    localparam logic [7:0]  ADDR_TORQUE = 8'h28;
    localparam logic [7:0]  ADDR_POS    = 8'h38;
    localparam logic [7:0]  ADDR_GOAL   = 8'h2A;
    localparam logic [7:0]  TORQUE_ON   = 8'h01;
    localparam logic [7:0]  TORQUE_OFF  = 8'h00;
    localparam logic [7:0]  READ_LEN    = 8'h02;

    localparam logic [7:0]  RST_SERVO_ID  = 8'd1;
    localparam logic [15:0] RST_POS_MIN   = 16'd1000;
    localparam logic [15:0] RST_POS_MAX   = 16'd2100;
    localparam logic [15:0] RST_VEL_LIMIT = 16'd100;

    // Reply byte positions.
    localparam logic [2:0]  RX_SYNC1  = 3'd1;
    localparam logic [2:0]  RX_ID     = 3'd2;
    localparam logic [2:0]  RX_POS_LO = 3'd5;
    localparam logic [2:0]  RX_POS_HI = 3'd6;
    localparam logic [2:0]  RX_LAST   = 3'd7;

    // Index of the checksum byte in short and long frames.
    localparam logic [3:0]  LAST_SHORT = 4'd7;
    localparam logic [3:0]  LAST_SET   = 4'd12;

endpackage

`default_nettype wire

// ===== rtl/spf_cmd_if.sv =====
// Command channel: valid/ready handshake with the command word payload.
`default_nettype none

interface spf_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] goal_position;
    logic [15:0] target_velocity;
    logic [7:0]  rx_byte;

    modport source (output valid, output operation, output goal_position,
                    output target_velocity, output rx_byte, input ready);
    modport sink   (input valid, input operation, input goal_position,
                    input target_velocity, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/spf_res_if.sv =====
// Result channel: valid/ready handshake with the result word payload.
`default_nettype none

interface spf_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] reported_pos;

    modport source (output valid, output kind, output tx_byte, output last,
                    output reported_pos, input ready);
    modport sink   (input valid, input kind, input tx_byte, input last,
                    input reported_pos, output ready);
endinterface

`default_nettype wire

// ===== rtl/spf_front.sv =====
// Front end: accepts command words, clamps set-point values and runs the reply parser.
`default_nettype none

module spf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    spf_cmd_if.sink               cmd,
    input  spf_pkg::spf_cfg_t     cfg,
    input  wire logic             full,
    output logic                  push,
    output spf_pkg::spf_job_t     push_job
);
    import spf_pkg::*;

    logic       accept;
    spf_op_t    op;
    logic [15:0] pos_clamped;
    logic [15:0] vel_clamped;
    logic [15:0] reply_pos;

    logic [2:0] rx_count_reg, rx_count_next;
    logic       rx_idle_reg, rx_idle_next;
    logic       rx_good_reg, rx_good_next;
    logic [7:0] rx_lo_reg, rx_lo_next;
    logic [7:0] rx_hi_reg, rx_hi_next;

    assign cmd.ready = !full;
    assign accept    = cmd.valid && !full;
    assign op        = spf_op_t'(cmd.operation);
    assign reply_pos = {rx_hi_reg, rx_lo_reg};

    always_comb
    begin
        if (cmd.goal_position < cfg.pos_min)
            pos_clamped = cfg.pos_min;
        else if (cmd.goal_position > cfg.pos_max)
            pos_clamped = cfg.pos_max;
        else
            pos_clamped = cmd.goal_position;
        vel_clamped = (cmd.target_velocity > cfg.vel_limit) ? cfg.vel_limit
                                                            : cmd.target_velocity;
    end

    always_comb
    begin
        push          = 1'b0;
        push_job      = '0;
        rx_count_next = rx_count_reg;
        rx_idle_next  = rx_idle_reg;
        rx_good_next  = rx_good_reg;
        rx_lo_next    = rx_lo_reg;
        rx_hi_next    = rx_hi_reg;
        if (accept)
        begin
            unique case (op)
                OP_ENABLE:
                begin
                    push           = 1'b1;
                    push_job.frame = FRM_ENABLE;
                end
                OP_DISABLE:
                begin
                    push           = 1'b1;
                    push_job.frame = FRM_DISABLE;
                end
                OP_READ:
                begin
                    push           = 1'b1;
                    push_job.frame = FRM_READ;
                    rx_idle_next   = 1'b0;
                    rx_count_next  = '0;
                    rx_good_next   = 1'b1;
                    rx_lo_next     = '0;
                    rx_hi_next     = '0;
                end
                OP_SET:
                begin
                    push           = 1'b1;
                    push_job.frame = FRM_SET;
                    push_job.pos   = pos_clamped;
                    push_job.vel   = vel_clamped;
                end
                OP_RX_BYTE:
                begin
                    if (!rx_idle_reg)
                    begin
                        if (rx_count_reg <= RX_SYNC1 && cmd.rx_byte != SYNC_BYTE)
                            rx_good_next = 1'b0;
                        if (rx_count_reg == RX_ID && cmd.rx_byte != cfg.servo_id)
                            rx_good_next = 1'b0;
                        if (rx_count_reg == RX_POS_LO)
                            rx_lo_next = cmd.rx_byte;
                        if (rx_count_reg == RX_POS_HI)
                            rx_hi_next = cmd.rx_byte;
                        if (rx_count_reg == RX_LAST)
                        begin
                            // Header flags and both position bytes are already stored.
                            push               = 1'b1;
                            push_job.is_report = 1'b1;
                            if (rx_good_reg && reply_pos >= cfg.pos_min
                                && reply_pos <= cfg.pos_max)
                                push_job.pos = reply_pos;
                            rx_count_next = '0;
                            rx_idle_next  = 1'b1;
                            rx_good_next  = 1'b1;
                        end
                        else
                        begin
                            rx_count_next = rx_count_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= '0;
            rx_idle_reg  <= 1'b1;
            rx_good_reg  <= 1'b1;
            rx_lo_reg    <= '0;
            rx_hi_reg    <= '0;
        end
        else
        begin
            rx_count_reg <= rx_count_next;
            rx_idle_reg  <= rx_idle_next;
            rx_good_reg  <= rx_good_next;
            rx_lo_reg    <= rx_lo_next;
            rx_hi_reg    <= rx_hi_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spf_queue.sv =====
// Small job queue between the front end and the serializer.
`default_nettype none

module spf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  spf_pkg::spf_job_t     push_job,
    output logic                  full,
    input  wire logic             pop,
    output spf_pkg::spf_job_t     head,
    output logic                  empty
);
    import spf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    spf_job_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spf_back.sv =====
// Serializer: turns queued jobs into frame bytes with checksum, or position reports.
`default_nettype none

module spf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       servo_id,
    input  wire logic             empty,
    input  spf_pkg::spf_job_t     head,
    output logic                  pop,
    spf_res_if.source             res
);
    import spf_pkg::*;

    logic        busy_reg, busy_next;
    logic [3:0]  idx_reg, idx_next;
    spf_job_t    job_reg, job_next;
    logic [7:0]  sum_reg, sum_next;

    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [15:0] rpos_reg;

    logic        out_free, emit, is_last;
    spf_job_t    cur;
    logic [3:0]  cur_idx;
    logic [7:0]  cur_byte;
    logic [7:0]  chk;

    assign out_free = !valid_reg || res.ready;
    assign emit     = out_free && (busy_reg || !empty);
    assign pop      = emit && !busy_reg;
    assign cur      = busy_reg ? job_reg : head;
    assign cur_idx  = busy_reg ? idx_reg : 4'd0;
    assign chk      = ~sum_reg;
    assign is_last  = (cur_idx == ((cur.frame == FRM_SET) ? LAST_SET : LAST_SHORT));

    always_comb
    begin
        unique case (cur_idx)
            4'd0, 4'd1: cur_byte = SYNC_BYTE;
            4'd2:       cur_byte = servo_id;
            4'd3:       cur_byte = (cur.frame == FRM_SET) ? LEN_SET : LEN_SHORT;
            4'd4:       cur_byte = (cur.frame == FRM_READ) ? INST_READ : INST_WRITE;
            4'd5:
            begin
                unique case (cur.frame)
                    FRM_READ: cur_byte = ADDR_POS;
                    FRM_SET:  cur_byte = ADDR_GOAL;
                    default:  cur_byte = ADDR_TORQUE;
                endcase
            end
            4'd6:
            begin
                unique case (cur.frame)
                    FRM_ENABLE:  cur_byte = TORQUE_ON;
                    FRM_DISABLE: cur_byte = TORQUE_OFF;
                    FRM_READ:    cur_byte = READ_LEN;
                    default:     cur_byte = cur.pos[7:0];
                endcase
            end
            4'd7:       cur_byte = (cur.frame == FRM_SET) ? cur.pos[15:8] : chk;
            4'd10:      cur_byte = cur.vel[7:0];
            4'd11:      cur_byte = cur.vel[15:8];
            4'd12:      cur_byte = chk;
            default:    cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        job_next  = job_reg;
        sum_next  = sum_reg;
        if (emit && !cur.is_report)
        begin
            // The checksum covers every byte from the servo id onward.
            sum_next = (cur_idx < 4'd2) ? 8'h00 : sum_reg + cur_byte;
            job_next = cur;
            if (is_last)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                busy_next = 1'b1;
                idx_next  = cur_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (emit)
                valid_reg <= 1'b1;
            else if (res.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        sum_reg <= sum_next;
        if (emit)
        begin
            kind_reg <= cur.is_report;
            byte_reg <= cur.is_report ? 8'h00 : cur_byte;
            last_reg <= cur.is_report || is_last;
            rpos_reg <= cur.is_report ? cur.pos : 16'h0000;
        end
    end

    assign res.valid        = valid_reg;
    assign res.kind         = kind_reg;
    assign res.tx_byte      = byte_reg;
    assign res.last         = last_reg;
    assign res.reported_pos = rpos_reg;

endmodule

`default_nettype wire

// ===== rtl/servo_packet_framer.sv =====
// Top level of the servo packet framer: configuration registers, front end, queue and serializer.
//
// The block builds instruction frames for a serial bus servo and parses its position replies.
// Command words arrive on the cmd channel (valid/ready). Enable torque, disable torque and read
// position each produce an 8-byte frame; set position produces a 13-byte frame with the
// position and velocity clamped to the configured limits. Every frame starts FF FF id and ends
// with the inverted low byte of the sum of all bytes after the two sync bytes. A read request
// arms the reply parser; the next eight received-byte words are checked and then yield one
// position report word (0 when the header is bad or the position is outside the limits).
// Result words leave on the res channel, one per cycle while the receiver is ready.
// The first result word of an item passes through the job queue and the registered output stage.
// The serializer emits one word per cycle while the receiver is ready, so a frame occupies it for
// one word per byte and a report for a single word; the front end keeps accepting commands
// until the job queue (QUEUE_DEPTH entries) is full.
// When the receiver stalls, the output word is held and the queue absorbs new commands;
// cmd.ready drops only once the queue is full. Reset loads the default configuration (id 1,
// position 1000..2100, speed 100), disarms the parser and empties the queue. Configuration
// must be written by the user only while the block is idle; the block does not enforce it.
`default_nettype none

module servo_packet_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    spf_cmd_if.sink          cmd,
    spf_res_if.source        res
);
    import spf_pkg::*;

    spf_cfg_t cfg_reg;
    logic     q_push, q_full, q_pop, q_empty;
    spf_job_t q_in_job, q_head;

    // Configuration registers; indexes follow the register list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.servo_id  <= RST_SERVO_ID;
            cfg_reg.pos_min   <= RST_POS_MIN;
            cfg_reg.pos_max   <= RST_POS_MAX;
            cfg_reg.vel_limit <= RST_VEL_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (spf_cfg_idx_t'(cfg_index))
                CFG_SERVO_ID:  cfg_reg.servo_id  <= cfg_data[7:0];
                CFG_POS_MIN:   cfg_reg.pos_min   <= cfg_data;
                CFG_POS_MAX:   cfg_reg.pos_max   <= cfg_data;
                CFG_VEL_LIMIT: cfg_reg.vel_limit <= cfg_data;
                default:       cfg_reg.servo_id  <= cfg_reg.servo_id;
            endcase
        end
    end

    // The front end classifies each command and turns it into one job, or none at all.
    spf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .full     (q_full),
        .push     (q_push),
        .push_job (q_in_job)
    );

    // The queue lets the front end run ahead while a long frame is being sent.
    spf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // The serializer sends each job byte by byte through a registered output stage.
    spf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .servo_id (cfg_reg.servo_id),
        .empty    (q_empty),
        .head     (q_head),
        .pop      (q_pop),
        .res      (res)
    );

endmodule

`default_nettype wire

// ===== sim/servo_packet_framer_tb.sv =====
// Self-checking testbench of the servo packet framer: directed table, then randomized phases.
`default_nettype none

module servo_packet_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spf_pkg::*;

    // Half of the 10 ns clock period.
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    // Longest idle stretch either side draws before a word.
    localparam int MAX_WAIT      = 18;
    // Quiet cycles after the last expected word, before a register write or the end.
    localparam int SETTLE_CYCLES = 24;
    // Worst case is roughly 400 items, each 13 words with a full stall per word plus a
    // full sender gap. The limit is several times that worst case.
    localparam int CYCLE_LIMIT   = 600000;
    // Counted command words per random phase.
    localparam int PHASE_WORDS   = 38;
    localparam int NUM_PHASES    = 8;
    localparam int PRINT_CAP     = 40;

    // Operations the block has no use for.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Kinds of result word.
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // One result word as it appears on the res channel.
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] reported_pos;
    } bus_word_t;

    // One row of the directed table. Where has_golden is set, golden is the checksum
    // byte of the frame or the reported position, typed in by hand.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] tpos;
        logic [15:0] tvel;
        logic [7:0]  rb;
        logic        has_golden;
        logic [15:0] golden;
    } cmd_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    spf_cmd_if cmd_ch ();
    spf_res_if res_ch ();

    servo_packet_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and of the reply parser.
    // ------------------------------------------------------------------
    spf_cfg_t   model_cfg;
    logic       rx_armed;
    logic [2:0] rx_taken;
    logic       rx_header_ok;
    logic [7:0] rx_lo;
    logic [7:0] rx_hi;

    // Result words the block owes us, oldest first.
    bus_word_t words_due[$];

    int  failures        = 0;
    int  words_sent      = 0;
    int  frames_checked  = 0;
    int  reports_checked = 0;
    int  zero_reports    = 0;
    int  cycle_count     = 0;
    // While calm is set neither side idles, which gives stretches of full throughput.
    bit  calm            = 1'b0;
    // Cycles the sender waits before its next word; drawn when a word is accepted so
    // that valid is either held high or lowered exactly once in that time step.
    int  next_gap        = 0;

    function automatic int pick_wait();
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void push_word(input logic kind, input logic [7:0] b, input logic fin,
                                      input logic [15:0] pos);
        bus_word_t w;
        w.kind         = kind;
        w.tx_byte      = b;
        w.last         = fin;
        w.reported_pos = pos;
        words_due.insert(words_due.size(), w);
    endfunction

    // Queues a whole frame: two sync bytes, the servo id, the body (byte 0 in the low
    // bits) and the inverted low byte of the sum of everything after the sync bytes.
    function automatic int predict_frame(input logic [71:0] body, input int body_len);
        logic [7:0] sum;
        sum = model_cfg.servo_id;
        push_word(KIND_FRAME, SYNC_BYTE, 1'b0, 16'd0);
        push_word(KIND_FRAME, SYNC_BYTE, 1'b0, 16'd0);
        push_word(KIND_FRAME, model_cfg.servo_id, 1'b0, 16'd0);
        for (int i = 0; i < body_len; i++) begin
            sum = sum + body[8*i +: 8];
            push_word(KIND_FRAME, body[8*i +: 8], 1'b0, 16'd0);
        end
        push_word(KIND_FRAME, ~sum, 1'b1, 16'd0);
        return body_len + 4;
    endfunction

    // Works out the result words of one accepted command word and queues them.
    // counted is cleared for words the block simply drops.
    function automatic int predict_servo_words(input logic [2:0] op, input logic [15:0] tpos,
                                               input logic [15:0] tvel, input logic [7:0] rb,
                                               output bit counted);
        logic [15:0] pos;
        logic [15:0] vel;
        int          produced;
        produced = 0;
        counted  = 1'b1;
        case (op)
            OP_ENABLE:
                produced = predict_frame({40'd0, TORQUE_ON, ADDR_TORQUE, INST_WRITE, LEN_SHORT},
                                         4);
            OP_DISABLE:
                produced = predict_frame({40'd0, TORQUE_OFF, ADDR_TORQUE, INST_WRITE,
                                          LEN_SHORT}, 4);
            OP_READ: begin
                // A read always restarts the parser, dropping any partial reply.
                rx_armed     = 1'b1;
                rx_taken     = 3'd0;
                rx_header_ok = 1'b1;
                rx_lo        = 8'd0;
                rx_hi        = 8'd0;
                produced = predict_frame({40'd0, READ_LEN, ADDR_POS, INST_READ, LEN_SHORT}, 4);
            end
            OP_SET: begin
                // The lower limit is tested first, so it wins for values below it when the limits cross.
                pos = tpos;
                if (pos < model_cfg.pos_min)
                    pos = model_cfg.pos_min;
                else if (pos > model_cfg.pos_max)
                    pos = model_cfg.pos_max;
                vel = (tvel > model_cfg.vel_limit) ? model_cfg.vel_limit : tvel;
                produced = predict_frame({vel[15:8], vel[7:0], 16'd0, pos[15:8], pos[7:0],
                                          ADDR_GOAL, INST_WRITE, LEN_SET}, 9);
            end
            OP_RX_BYTE: begin
                if (!rx_armed) begin
                    counted = 1'b0;
                end else begin
                    if (rx_taken <= RX_SYNC1 && rb != SYNC_BYTE)
                        rx_header_ok = 1'b0;
                    if (rx_taken == RX_ID && rb != model_cfg.servo_id)
                        rx_header_ok = 1'b0;
                    if (rx_taken == RX_POS_LO)
                        rx_lo = rb;
                    if (rx_taken == RX_POS_HI)
                        rx_hi = rb;
                    if (rx_taken != RX_LAST) begin
                        rx_taken = rx_taken + 3'd1;
                    end else begin
                        // The reply checksum is never looked at.
                        pos = {rx_hi, rx_lo};
                        if (!rx_header_ok || pos < model_cfg.pos_min || pos > model_cfg.pos_max)
                            pos = 16'd0;
                        push_word(KIND_REPORT, 8'h00, 1'b1, pos);
                        rx_armed     = 1'b0;
                        rx_taken     = 3'd0;
                        rx_header_ok = 1'b1;
                        produced = 1;
                    end
                end
            end
            default:
                counted = 1'b0;
        endcase
        return produced;
    endfunction

    // Values at and just beyond a pair of limits, 0000 and FFFF, one in between, plus a few at random.
    function automatic logic [15:0] pick_limit_value(input logic [15:0] lo, input logic [15:0] hi);
        logic [15:0] pick;
        case ($urandom_range(0, 7))
            0:       pick = 16'h0000;
            1:       pick = 16'hFFFF;
            2:       pick = lo;
            3:       pick = hi;
            4:       pick = lo - 16'd1;
            5:       pick = hi + 16'd1;
            6:       pick = (lo <= hi) ? 16'($urandom_range(int'(hi), int'(lo)))
                                       : 16'($urandom());
            default: pick = 16'($urandom());
        endcase
        return pick;
    endfunction

    function automatic cmd_row_t row(input logic [2:0] op, input logic [15:0] tpos,
                                     input logic [15:0] tvel, input logic [7:0] rb,
                                     input logic has_golden, input logic [15:0] golden);
        return {op, tpos, tvel, rb, has_golden, golden};
    endfunction

    // ------------------------------------------------------------------
    // Command side. A word is offered after the drawn gap and held until the
    // block takes it; the predictor runs in the time step of acceptance.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [2:0] op, input logic [15:0] tpos,
                             input logic [15:0] tvel, input logic [7:0] rb, output int produced);
        bit counted;
        repeat (next_gap) @(posedge clk);
        cmd_ch.valid           <= 1'b1;
        cmd_ch.operation       <= op;
        cmd_ch.goal_position   <= tpos;
        cmd_ch.target_velocity <= tvel;
        cmd_ch.rx_byte         <= rb;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        produced = predict_servo_words(op, tpos, tvel, rb, counted);
        if (counted)
            words_sent++;
        next_gap = pick_wait();
        if (next_gap > 0)
            cmd_ch.valid <= 1'b0;
    endtask

    // Holds the command side until every owed word has come out, then lets the
    // block run on for a while in case a dropped or partial item is still in flight.
    task automatic settle_block();
        if (next_gap == 0)
            cmd_ch.valid <= 1'b0;
        next_gap = 0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges and mirrors them in the predictor.
    task automatic load_settings(input spf_cfg_t s);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SERVO_ID;
        cfg_data  <= {8'h00, s.servo_id};
        @(posedge clk);
        cfg_index <= CFG_POS_MIN;
        cfg_data  <= s.pos_min;
        @(posedge clk);
        cfg_index <= CFG_POS_MAX;
        cfg_data  <= s.pos_max;
        @(posedge clk);
        cfg_index <= CFG_VEL_LIMIT;
        cfg_data  <= s.vel_limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_cfg = s;
    endtask

    // A read request followed by the eight reply words. Most replies are well formed;
    // some carry a broken header byte, some are interrupted by other commands, and a few
    // are cut short by a second read, after which the reply starts over.
    task automatic run_reply_exchange();
        logic [63:0] reply;
        logic [15:0] pos;
        spf_op_t     other;
        int          produced;
        int          i;
        bit          restarted;
        pos   = pick_limit_value(model_cfg.pos_min, model_cfg.pos_max);
        reply = {8'($urandom()), pos[15:8], pos[7:0], 8'($urandom()), 8'($urandom()),
                 model_cfg.servo_id, SYNC_BYTE, SYNC_BYTE};
        if ($urandom_range(0, 4) == 0) begin
            i = $urandom_range(0, 2);
            reply[8*i +: 8] = reply[8*i +: 8] ^ 8'($urandom_range(1, 255));
        end
        send_word(OP_READ, 16'($urandom()), 16'($urandom()), 8'($urandom()), produced);
        restarted = 1'b0;
        i = 0;
        while (i < 8) begin
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0:       other = OP_ENABLE;
                    1:       other = OP_DISABLE;
                    default: other = OP_SET;
                endcase
                send_word(other, pick_limit_value(model_cfg.pos_min, model_cfg.pos_max),
                          pick_limit_value(16'd0, model_cfg.vel_limit), 8'($urandom()),
                          produced);
            end
            if (!restarted && i > 0 && $urandom_range(0, 24) == 0) begin
                restarted = 1'b1;
                send_word(OP_READ, 16'($urandom()), 16'($urandom()), 8'($urandom()), produced);
                i = 0;
            end
            send_word(OP_RX_BYTE, 16'($urandom()), 16'($urandom()), reply[8*i +: 8], produced);
            i++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls per word, and every accepted word is compared
    // with the oldest one owed.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int        gap;
        bus_word_t got;
        bus_word_t want;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = pick_wait();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            got = {res_ch.kind, res_ch.tx_byte, res_ch.last, res_ch.reported_pos};
            if (words_due.size() == 0) begin
                failures++;
                if (failures <= PRINT_CAP)
                    $display("%0t: unexpected result word, kind %0d byte %02h last %0d position %0d",
                             $time, got.kind, got.tx_byte, got.last, got.reported_pos);
            end else begin
                want = words_due.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= PRINT_CAP)
                        $display({"%0t: result word mismatch, expected kind %0d byte %02h ",
                                  "last %0d position %0d, got kind %0d byte %02h last %0d ",
                                  "position %0d"},
                                 $time, want.kind, want.tx_byte, want.last, want.reported_pos,
                                 got.kind, got.tx_byte, got.last, got.reported_pos);
                end
                if (want.kind == KIND_REPORT) begin
                    reports_checked++;
                    if (want.reported_pos == 16'd0)
                        zero_reports++;
                end else if (want.last) begin
                    frames_checked++;
                end
            end
            if (failures == PRINT_CAP + 1 && got !== want)
                $display("%0t: further mismatches are counted but not printed", $time);
        end
    end

    // Watchdog: a hung handshake or a lost word ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles, %0d words still owed",
                     $time, CYCLE_LIMIT, words_due.size());
            $display("servo_packet_framer_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin : stimulus
        cmd_row_t  script[$];
        spf_cfg_t  phase_cfg [NUM_PHASES];
        bus_word_t typed;
        logic [15:0] a;
        logic [15:0] b;
        int        produced;
        int        goal;
        int        roll;

        // Every input known from time zero; reset held low at the start.
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_SERVO_ID;
        cfg_data               <= 16'd0;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.operation       <= OP_ENABLE;
        cmd_ch.goal_position   <= 16'd0;
        cmd_ch.target_velocity <= 16'd0;
        cmd_ch.rx_byte         <= 8'd0;

        model_cfg    = {RST_SERVO_ID, RST_POS_MIN, RST_POS_MAX, RST_VEL_LIMIT};
        rx_armed     = 1'b0;
        rx_taken     = 3'd0;
        rx_header_ok = 1'b1;
        rx_lo        = 8'd0;
        rx_hi        = 8'd0;

        // Directed table, run on the reset settings (id 1, 1000..2100, speed 100).
        // Torque frames and the read frame have fixed checksums at id 1.
        script.insert(script.size(), row(OP_ENABLE,  16'h0000, 16'h0000, 8'h00, 1'b1, 16'h00CE));
        script.insert(script.size(), row(OP_DISABLE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'h00CF));
        // Set position at both extremes: clamped to 1000/0 and to 2100/100.
        script.insert(script.size(), row(OP_SET,     16'h0000, 16'h0000, 8'h00, 1'b1, 16'h00DD));
        script.insert(script.size(), row(OP_SET,     16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'h0028));
        // A reply byte with the parser not armed and an unused operation: both dropped.
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_SPARE_LO, 16'h1234, 16'h5678, 8'h9A, 1'b0, 16'h0));
        // Good reply carrying exactly the upper limit, 0x0834.
        script.insert(script.size(), row(OP_READ,    16'h0000, 16'h0000, 8'h00, 1'b1, 16'h00BE));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h01, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h34, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h08, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b1, 16'd2100));
        // A read while a reply is half in: the second read starts the parser over.
        script.insert(script.size(), row(OP_READ,    16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_READ,    16'h0000, 16'h0000, 8'h00, 1'b1, 16'h00BE));
        // Then a reply from the wrong servo: reported as zero though 1000 is in range.
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h02, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hE8, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h03, 1'b0, 16'h0000));
        script.insert(script.size(), row(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b1, 16'h0000));

        // Register settings of the random phases. Phase 0 keeps the reset values and
        // the last one returns to them; in between come the extremes, crossed limits
        // and random settings.
        phase_cfg[0] = {RST_SERVO_ID, RST_POS_MIN, RST_POS_MAX, RST_VEL_LIMIT};
        phase_cfg[1] = {8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF};
        phase_cfg[2] = {8'h00, 16'h0000, 16'h0000, 16'h0000};
        phase_cfg[3] = {8'($urandom()), 16'd3000, 16'd1000, 16'd500};
        phase_cfg[4] = {8'hA5, 16'hFFFF, 16'hFFFF, 16'h0001};
        a = 16'($urandom());
        b = 16'($urandom());
        phase_cfg[5] = {8'($urandom()), (a < b) ? a : b, (a < b) ? b : a,
                        16'($urandom_range(0, 2000))};
        phase_cfg[6] = {8'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
        phase_cfg[7] = {RST_SERVO_ID, RST_POS_MIN, RST_POS_MAX, RST_VEL_LIMIT};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Typed-in values replace the predicted checksum byte or
        // position, so those rows are checked against the hand value.
        foreach (script[k]) begin
            send_word(script[k].op, script[k].tpos, script[k].tvel, script[k].rb, produced);
            if (script[k].has_golden && produced > 0) begin
                typed = words_due[words_due.size() - 1];
                if (typed.kind == KIND_REPORT)
                    typed.reported_pos = script[k].golden;
                else
                    typed.tx_byte = script[k].golden[7:0];
                words_due[words_due.size() - 1] = typed;
            end
        end

        // Random part. Registers change only with the block drained.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                settle_block();
                load_settings(phase_cfg[phase]);
            end
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    // Let the result side empty completely before going on.
                    settle_block();
                end else if (roll < 10) begin
                    calm = !calm;
                end else if (roll < 62) begin
                    run_reply_exchange();
                end else if (roll < 80) begin
                    send_word(OP_SET, pick_limit_value(model_cfg.pos_min, model_cfg.pos_max),
                              pick_limit_value(16'd0, model_cfg.vel_limit), 8'($urandom()),
                              produced);
                end else begin
                    // Noise: any operation code, unused ones and stray reply bytes included.
                    send_word(3'($urandom_range(0, int'(OP_SPARE_HI))), 16'($urandom()),
                              16'($urandom()), 8'($urandom()), produced);
                end
            end
        end

        settle_block();

        $display("Covered %0d command words over %0d register settings.",
                 words_sent, NUM_PHASES);
        $display("Checked %0d frames and %0d position reports, %0d of them reported as zero.",
                 frames_checked, reports_checked, zero_reports);
        if (failures == 0)
            $display("servo_packet_framer_tb passed");
        else
            $display("servo_packet_framer_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
